>>> hdl/cubic_bspline_evaluator_macros.svh
// Assertion macros for the checker file of the spline evaluator.
// Depends on nothing; included by name where assertions are written.
`ifndef CUBIC_BSPLINE_EVALUATOR_MACROS_SVH
`define CUBIC_BSPLINE_EVALUATOR_MACROS_SVH

// Clocked property, switched off while reset is low.
`define CBS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked property that also holds while reset is low.
`define CBS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/cbs_pkg.sv
// Shared types, constants and the knot reset table of the spline evaluator.
// Depends on nothing; imported by cbs_div, the evaluator top level and its checker.
package cbs_pkg;

  localparam int KNOT_W = 24;
  localparam int COEF_W = 32;
  localparam int BAS_W  = 31;
  localparam int DIFF_W = 25;
  localparam int ACC_W  = 40;
  localparam int QF_W   = 30;

  localparam logic [BAS_W-1:0] Q30_ONE = 31'h4000_0000;

  typedef enum logic [1:0] {
    KIND_COEFF = 2'd0,
    KIND_KNOT  = 2'd1,
    KIND_EVAL  = 2'd2
  } cbs_kind_e;

  // Request to the shared fraction divider
  typedef struct packed {
    logic                     start;
    logic signed [DIFF_W-1:0] num;
    logic signed [DIFF_W-1:0] den;
  } cbs_div_req_t;

  // Knot value after reset; entries past the table repeat the last knot
  function automatic logic signed [KNOT_W-1:0] def_knot(input logic [6:0] idx);
    logic signed [KNOT_W-1:0] v;
    case (idx)
      7'd0:    v = -24'sd12800;
      7'd1:    v = -24'sd7680;
      7'd2:    v = -24'sd2560;
      7'd3:    v = 24'sd0;
      7'd4:    v = 24'sd5120;
      7'd5:    v = 24'sd12800;
      7'd6:    v = 24'sd30720;
      7'd7:    v = 24'sd64000;
      7'd8:    v = 24'sd128000;
      7'd9:    v = 24'sd512000;
      7'd10:   v = 24'sd896000;
      7'd11:   v = 24'sd1280000;
      7'd12:   v = 24'sd1920000;
      7'd13:   v = 24'sd2856960;
      7'd14:   v = 24'sd3502080;
      7'd15:   v = 24'sd4147200;
      7'd16:   v = 24'sd5068800;
      default: v = 24'sd6451200;
    endcase
    return v;
  endfunction

endpackage

>>> hdl/cbs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing; used for the knot, coefficient and basis stores.
module cbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry; read one entry, registered, in the cycle after its address
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/cbs_div.sv
// Shared fraction unit: num/den in Q1.30 clamped to [0, 1], one bit a cycle.
// Depends on cbs_pkg.
module cbs_div
  import cbs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cbs_div_req_t     req_i,
  output logic             done_o,
  output logic [BAS_W-1:0] quot_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [4:0]           cnt_q, cnt_d;
  logic [DIFF_W-1:0]    rem_q, rem_d;
  logic [DIFF_W-1:0]    den_q, den_d;
  logic [BAS_W-1:0]     quot_q, quot_d;
  logic [DIFF_W:0]      rem2;

  assign rem2 = {rem_q, 1'b0};

  // Resolve trivial fractions at once, else run the restoring loop
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    if (req_i.start) begin
      den_d = req_i.den;
      rem_d = req_i.num;
      cnt_d = 5'(QF_W);
      if (req_i.den <= 0 || req_i.num <= 0) begin
        quot_d = '0;
        done_d = 1'b1;
      end else if (req_i.num >= req_i.den) begin
        quot_d = Q30_ONE;
        done_d = 1'b1;
      end else begin
        quot_d = '0;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (rem2 >= {1'b0, den_q}) begin
        rem_d  = DIFF_W'(rem2 - {1'b0, den_q});
        quot_d = {quot_q[BAS_W-2:0], 1'b1};
      end else begin
        rem_d  = DIFF_W'(rem2);
        quot_d = {quot_q[BAS_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

>>> hdl/cubic_bspline_evaluator.sv
// Cubic B-spline evaluator: knot and coefficient stores, basis RAM, sequencer.
// Depends on cbs_pkg, cbs_ram and cbs_div.
//
// Usage: items arrive on the s_axis channel; s_axis_tuser carries the kind
// (write coefficient, write knot, evaluate). Writes give no beat. An evaluate
// beat yields one m_axis beat with the sum of coefficients times Q1.30 basis
// weights, saturated to signed 32 bits, and the in-range and saturated flags.
// A single shared 30-step fraction divider serves every basis division, and
// each store has a single read port.
// One item is worked at a time; s_axis_tready is high only when idle.
// Reset restores the 18 default knots and zero coefficients through valid
// bits, at once, with no clearing pass.
// A stalled receiver holds the result in the output register; the block
// still takes writes and starts a new evaluate, which waits for the slot.
module cubic_bspline_evaluator
  import cbs_pkg::*;
#(
  parameter int NUM_KNOTS = 18,
  parameter int NUM_COEFF = 14
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // index[4:0], coeff_value[36:5], knot_value[60:37], point[84:61], zero pad
  input  logic [87:0] s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // spline_value[31:0], in_range[32], saturated[33], zero pad
  output logic [39:0] m_axis_tdata
);

  localparam int KA    = $clog2(NUM_KNOTS);
  localparam int CA    = (NUM_COEFF > 1) ? $clog2(NUM_COEFF) : 1;
  localparam int NTERM = (NUM_COEFF < NUM_KNOTS - 4) ? NUM_COEFF : NUM_KNOTS - 4;
  localparam logic [KA-1:0] KLAST  = KA'(NUM_KNOTS - 1);
  localparam logic [KA-1:0] JLAST0 = KA'(NUM_KNOTS - 2);
  localparam logic [KA-1:0] TLAST  = KA'(NTERM - 1);

  typedef enum logic [25:0] {
    ST_IDLE = 26'h0000001, ST_RNG0 = 26'h0000002, ST_RNG1 = 26'h0000004,
    ST_RNG2 = 26'h0000008, ST_D0A  = 26'h0000010, ST_D0B  = 26'h0000020,
    ST_D0C  = 26'h0000040, ST_GA   = 26'h0000080, ST_GB   = 26'h0000100,
    ST_GC   = 26'h0000200, ST_GK1  = 26'h0000400, ST_GK2  = 26'h0000800,
    ST_GK3  = 26'h0001000, ST_GK4  = 26'h0002000, ST_GD1  = 26'h0004000,
    ST_GA1  = 26'h0008000, ST_GS2  = 26'h0010000, ST_GD2  = 26'h0020000,
    ST_GA2  = 26'h0040000, ST_GW   = 26'h0080000, ST_NEXT = 26'h0100000,
    ST_SA   = 26'h0200000, ST_SB   = 26'h0400000, ST_SC   = 26'h0800000,
    ST_SF   = 26'h1000000, ST_OUT  = 26'h2000000
  } cbs_state_e;

  // Input fields
  logic [1:0]               in_kind;
  logic [4:0]               in_index;
  logic [COEF_W-1:0]        in_coeff;
  logic [KNOT_W-1:0]        in_knot;
  logic signed [KNOT_W-1:0] in_point;
  logic                     in_beat;

  assign in_kind  = s_axis_tuser[1:0];
  assign in_index = s_axis_tdata[4:0];
  assign in_coeff = s_axis_tdata[36:5];
  assign in_knot  = s_axis_tdata[60:37];
  assign in_point = s_axis_tdata[84:61];
  assign in_beat  = s_axis_tvalid && s_axis_tready;

  cbs_state_e st_q, st_d;
  logic [KA-1:0]            j_q, j_d;
  logic [1:0]               d_q, d_d;
  logic signed [KNOT_W-1:0] t_q, t_d;
  logic [BAS_W-1:0]         b0_q, b0_d, b1_q, b1_d;
  logic signed [KNOT_W-1:0] kj_q, kj_d, kjd_q, kjd_d, kj1_q, kj1_d, kjd1_q, kjd1_d;
  logic [31:0]              part_q, part_d;
  logic signed [63:0]       prod_q, prod_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic [31:0]              res_val_q, res_val_d;
  logic                     res_inr_q, res_inr_d, res_sat_q, res_sat_d;
  logic                     m_val_q, m_val_d;
  logic [33:0]              m_dat_q, m_dat_d;

  // Store control
  logic [NUM_KNOTS-1:0]     kval_q;
  logic [NUM_COEFF-1:0]     cval_q;
  logic                     kvrd_q, cvrd_q;
  logic [KA-1:0]            kard_q;
  logic                     kwe, cwe;
  logic [KA-1:0]            kaddr, bwaddr, braddr;
  logic [CA-1:0]            caddr;
  logic                     bwe;
  logic [BAS_W-1:0]         bwdata;
  logic [KNOT_W-1:0]        kram_rdata;
  logic [COEF_W-1:0]        cram_rdata;
  logic [BAS_W-1:0]         bas_rd;
  logic signed [KNOT_W-1:0] knot_rd;
  logic signed [COEF_W-1:0] coeff_rd;

  // Divider and multiplier
  cbs_div_req_t             div_req;
  logic                     div_done;
  logic [BAS_W-1:0]         div_quot;
  logic signed [31:0]       mul_a, mul_b;
  logic signed [63:0]       mul_p;
  logic signed [DIFF_W-1:0] t_x, kj_x, kjd_x, kj1_x, kjd1_x;
  logic signed [ACC_W-1:0]  term;

  assign kwe = in_beat && (in_kind == KIND_KNOT) && (32'(in_index) < NUM_KNOTS);
  assign cwe = in_beat && (in_kind == KIND_COEFF) && (32'(in_index) < NUM_COEFF);

  cbs_ram #(.WIDTH(KNOT_W), .DEPTH(NUM_KNOTS)) u_knot_ram (
    .clk_i   (clk_i),
    .we_i    (kwe),
    .waddr_i (KA'(in_index)),
    .wdata_i (in_knot),
    .raddr_i (kaddr),
    .rdata_o (kram_rdata)
  );

  cbs_ram #(.WIDTH(COEF_W), .DEPTH(NUM_COEFF)) u_coeff_ram (
    .clk_i   (clk_i),
    .we_i    (cwe),
    .waddr_i (CA'(in_index)),
    .wdata_i (in_coeff),
    .raddr_i (caddr),
    .rdata_o (cram_rdata)
  );

  cbs_ram #(.WIDTH(BAS_W), .DEPTH(NUM_KNOTS)) u_basis_ram (
    .clk_i   (clk_i),
    .we_i    (bwe),
    .waddr_i (bwaddr),
    .wdata_i (bwdata),
    .raddr_i (braddr),
    .rdata_o (bas_rd)
  );

  cbs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // Unwritten entries read as their reset values
  assign knot_rd  = kvrd_q ? $signed(kram_rdata) : def_knot(7'(kard_q));
  assign coeff_rd = cvrd_q ? $signed(cram_rdata) : '0;

  assign t_x    = DIFF_W'(t_q);
  assign kj_x   = DIFF_W'(kj_q);
  assign kjd_x  = DIFF_W'(kjd_q);
  assign kj1_x  = DIFF_W'(kj1_q);
  assign kjd1_x = DIFF_W'(kjd1_q);
  assign term   = ACC_W'($signed(prod_q[63:30]));
  assign mul_p  = mul_a * mul_b;

  assign s_axis_tready = (st_q == ST_IDLE);

  // Sequencer: range check, degree-zero pass, three recursion passes, sum
  always_comb begin
    st_d      = st_q;
    j_d       = j_q;
    d_d       = d_q;
    t_d       = t_q;
    b0_d      = b0_q;
    b1_d      = b1_q;
    kj_d      = kj_q;
    kjd_d     = kjd_q;
    kj1_d     = kj1_q;
    kjd1_d    = kjd1_q;
    part_d    = part_q;
    prod_d    = prod_q;
    acc_d     = acc_q;
    res_val_d = res_val_q;
    res_inr_d = res_inr_q;
    res_sat_d = res_sat_q;
    kaddr     = '0;
    braddr    = '0;
    bwaddr    = j_q;
    caddr     = CA'(j_q);
    bwe       = 1'b0;
    bwdata    = '0;
    div_req   = '0;
    mul_a     = $signed({1'b0, div_quot});
    mul_b     = (st_q == ST_GD2) ? $signed({1'b0, b1_q}) : $signed({1'b0, b0_q});
    unique case (st_q)
      ST_IDLE: begin
        if (in_beat && in_kind == KIND_EVAL) begin
          t_d  = in_point;
          st_d = ST_RNG0;
        end
      end
      ST_RNG0: begin
        kaddr = '0;
        st_d  = ST_RNG1;
      end
      ST_RNG1: begin
        kj_d  = knot_rd;
        kaddr = KLAST;
        st_d  = ST_RNG2;
      end
      ST_RNG2: begin
        if (kj_q <= t_q && t_q < knot_rd) begin
          j_d  = '0;
          st_d = ST_D0A;
        end else begin
          res_val_d = '0;
          res_inr_d = 1'b0;
          res_sat_d = 1'b0;
          st_d      = ST_OUT;
        end
      end
      ST_D0A: begin
        kaddr = j_q;
        st_d  = ST_D0B;
      end
      ST_D0B: begin
        kj_d  = knot_rd;
        kaddr = j_q + KA'(1);
        st_d  = ST_D0C;
      end
      ST_D0C: begin
        bwe    = 1'b1;
        bwdata = (kj_q <= t_q && t_q < knot_rd) ? Q30_ONE : '0;
        if (j_q == JLAST0) begin
          j_d  = '0;
          d_d  = 2'd1;
          st_d = ST_GA;
        end else begin
          j_d  = j_q + KA'(1);
          st_d = ST_D0A;
        end
      end
      ST_GA: begin
        braddr = j_q;
        st_d   = ST_GB;
      end
      ST_GB: begin
        b0_d   = bas_rd;
        braddr = j_q + KA'(1);
        st_d   = ST_GC;
      end
      ST_GC: begin
        b1_d = bas_rd;
        if (b0_q == '0 && bas_rd == '0) begin
          st_d = ST_NEXT;
        end else begin
          kaddr = j_q;
          st_d  = ST_GK1;
        end
      end
      ST_GK1: begin
        kj_d  = knot_rd;
        kaddr = j_q + KA'(d_q);
        st_d  = ST_GK2;
      end
      ST_GK2: begin
        kjd_d = knot_rd;
        kaddr = j_q + KA'(1);
        st_d  = ST_GK3;
      end
      ST_GK3: begin
        kj1_d = knot_rd;
        kaddr = j_q + KA'(d_q) + KA'(1);
        st_d  = ST_GK4;
      end
      ST_GK4: begin
        kjd1_d = knot_rd;
        part_d = '0;
        if (b0_q != '0) begin
          div_req.start = 1'b1;
          div_req.num   = t_x - kj_x;
          div_req.den   = kjd_x - kj_x;
          st_d          = ST_GD1;
        end else begin
          st_d = ST_GS2;
        end
      end
      ST_GD1: begin
        if (div_done) begin
          prod_d = mul_p;
          st_d   = ST_GA1;
        end
      end
      ST_GA1: begin
        part_d = part_q + prod_q[61:30];
        st_d   = ST_GS2;
      end
      ST_GS2: begin
        if (b1_q != '0) begin
          div_req.start = 1'b1;
          div_req.num   = kjd1_x - t_x;
          div_req.den   = kjd1_x - kj1_x;
          st_d          = ST_GD2;
        end else begin
          st_d = ST_GW;
        end
      end
      ST_GD2: begin
        if (div_done) begin
          prod_d = mul_p;
          st_d   = ST_GA2;
        end
      end
      ST_GA2: begin
        part_d = part_q + prod_q[61:30];
        st_d   = ST_GW;
      end
      ST_GW: begin
        bwe    = 1'b1;
        bwdata = (part_q > 32'(Q30_ONE)) ? Q30_ONE : part_q[BAS_W-1:0];
        st_d   = ST_NEXT;
      end
      ST_NEXT: begin
        if (j_q == JLAST0 - KA'(d_q)) begin
          j_d = '0;
          if (d_q == 2'd3) begin
            acc_d = '0;
            st_d  = ST_SA;
          end else begin
            d_d  = d_q + 2'd1;
            st_d = ST_GA;
          end
        end else begin
          j_d  = j_q + KA'(1);
          st_d = ST_GA;
        end
      end
      ST_SA: begin
        braddr = j_q;
        caddr  = CA'(j_q);
        st_d   = ST_SB;
      end
      ST_SB: begin
        mul_a  = coeff_rd;
        mul_b  = $signed({1'b0, bas_rd});
        prod_d = mul_p;
        st_d   = ST_SC;
      end
      ST_SC: begin
        acc_d = acc_q + term;
        if (j_q == TLAST) begin
          st_d = ST_SF;
        end else begin
          j_d  = j_q + KA'(1);
          st_d = ST_SA;
        end
      end
      ST_SF: begin
        res_inr_d = 1'b1;
        if (acc_q > ACC_W'(64'sh7FFF_FFFF)) begin
          res_val_d = 32'h7FFF_FFFF;
          res_sat_d = 1'b1;
        end else if (acc_q < -ACC_W'(64'sh8000_0000)) begin
          res_val_d = 32'h8000_0000;
          res_sat_d = 1'b1;
        end else begin
          res_val_d = acc_q[31:0];
          res_sat_d = 1'b0;
        end
        st_d = ST_OUT;
      end
      ST_OUT: begin
        if (!m_val_q || m_axis_tready) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // Load the output register when the slot is free, drop it when taken
  always_comb begin
    m_val_d = m_val_q;
    m_dat_d = m_dat_q;
    if (st_q == ST_OUT && (!m_val_q || m_axis_tready)) begin
      m_val_d = 1'b1;
      m_dat_d = {res_sat_q, res_inr_q, res_val_q};
    end else if (m_axis_tready) begin
      m_val_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      m_val_q <= 1'b0;
      kval_q  <= '0;
      cval_q  <= '0;
      j_q     <= '0;
      d_q     <= '0;
    end else begin
      st_q    <= st_d;
      m_val_q <= m_val_d;
      j_q     <= j_d;
      d_q     <= d_d;
      if (kwe) begin
        kval_q[KA'(in_index)] <= 1'b1;
      end
      if (cwe) begin
        cval_q[CA'(in_index)] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    t_q       <= t_d;
    b0_q      <= b0_d;
    b1_q      <= b1_d;
    kj_q      <= kj_d;
    kjd_q     <= kjd_d;
    kj1_q     <= kj1_d;
    kjd1_q    <= kjd1_d;
    part_q    <= part_d;
    prod_q    <= prod_d;
    acc_q     <= acc_d;
    res_val_q <= res_val_d;
    res_inr_q <= res_inr_d;
    res_sat_q <= res_sat_d;
    m_dat_q   <= m_dat_d;
    kvrd_q    <= kval_q[kaddr];
    kard_q    <= kaddr;
    cvrd_q    <= cval_q[caddr];
  end

  assign m_axis_tvalid = m_val_q;
  assign m_axis_tdata  = {6'd0, m_dat_q};

endmodule

>>> hdl/cbs_checker.sv
// Port-level checks for the spline evaluator, bound to its top level.
// Depends on cbs_pkg and cubic_bspline_evaluator_macros.svh.
`include "cubic_bspline_evaluator_macros.svh"

module cbs_checker
  import cbs_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  // Hold a stalled result beat
  `CBS_ASSERT(a_hold, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "result changed while stalled")

  // Out of range gives zero with no saturation
  `CBS_ASSERT(a_range, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tdata[32]) |-> (m_axis_tdata[31:0] == 32'd0 && !m_axis_tdata[33]), "out-of-range result not zero")

  // Saturation clips to an end of the range
  `CBS_ASSERT(a_sat, clk_i, rst_ni, (m_axis_tvalid && m_axis_tdata[33]) |-> (m_axis_tdata[31:0] == 32'h7FFF_FFFF || m_axis_tdata[31:0] == 32'h8000_0000), "saturated value not at a limit")

  // An evaluate beat blocks the input next cycle
  `CBS_ASSERT(a_busy, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_EVAL) |=> !s_axis_tready, "input open during evaluation")

  // No result beat during reset
  `CBS_ASSERT_ALWAYS(a_rst, clk_i, !rst_ni |-> !m_axis_tvalid, "result valid in reset")

endmodule

bind cubic_bspline_evaluator cbs_checker u_cbs_checker (.*);

>>> sim/tb_cubic_bspline_evaluator.sv
// Testbench for the cubic B-spline evaluator: random and directed stream beats,
// a behavioral Cox-de Boor predictor and a scoreboard. Depends on cbs_pkg and cubic_bspline_evaluator.
`timescale 1ns / 100ps

module tb_cubic_bspline_evaluator
  import cbs_pkg::*;
;

  localparam int NK = 18;
  localparam int NC = 14;
  localparam logic signed [63:0] ONE_Q30 = 64'sd1 << 30;

  typedef struct packed {
    cbs_kind_e          kind;
    logic [4:0]         index;
    logic signed [31:0] coeff;
    logic signed [23:0] knot;
    logic signed [23:0] point;
  } item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               in_range;
    logic               sat;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  item_t   pending_q[$];
  result_t expected_q[$];
  logic signed [23:0] knots[NK];
  logic signed [31:0] coeffs[NC];
  int errors = 0;
  bit stim_done = 0;
  int send_wait = 0;
  int recv_wait = 0;

  cubic_bspline_evaluator #(.NUM_KNOTS(NK), .NUM_COEFF(NC)) dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Q1.30 fraction clamped to [0, 1]; zero for a non-positive gap
  function automatic logic signed [63:0] frac_q30(logic signed [63:0] num,
                                                  logic signed [63:0] den);
    if (den <= 0 || num <= 0) return 0;
    if (num >= den) return ONE_Q30;
    return (num <<< 30) / den;
  endfunction

  // floor(a * b / 2^30)
  function automatic logic signed [63:0] mul_floor(logic signed [63:0] a,
                                                   logic signed [63:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p >>> 30;
  endfunction

  function automatic result_t spline_at(logic signed [23:0] pt);
    logic signed [63:0] b[NK];
    logic signed [63:0] t, v, f1, f2, acc;
    result_t r;
    t = pt;
    r = '0;
    if (!(knots[0] <= t && t < knots[NK-1])) return r;
    r.in_range = 1'b1;
    for (int j = 0; j < NK; j++)
      b[j] = (j + 1 < NK && knots[j] <= t && t < knots[j+1]) ? ONE_Q30 : 0;
    for (int d = 1; d <= 3; d++)
      for (int j = 0; j + d + 1 < NK; j++) begin
        f1 = frac_q30(t - knots[j], 64'(knots[j+d]) - knots[j]);
        f2 = frac_q30(64'(knots[j+d+1]) - t, 64'(knots[j+d+1]) - knots[j+1]);
        v = mul_floor(f1, b[j]) + mul_floor(f2, b[j+1]);
        if (v < 0) v = 0;
        if (v > ONE_Q30) v = ONE_Q30;
        b[j] = v;
      end
    acc = 0;
    for (int i = 0; i < NC && i + 4 <= NK - 1; i++) acc += mul_floor(coeffs[i], b[i]);
    if (acc > 64'sd2147483647) begin
      acc = 64'sd2147483647;
      r.sat = 1'b1;
    end
    if (acc < -64'sd2147483648) begin
      acc = -64'sd2147483648;
      r.sat = 1'b1;
    end
    r.value = acc[31:0];
    return r;
  endfunction

  // Update stores or queue the expected result of one accepted beat
  task automatic apply_item(item_t it);
    case (it.kind)
      KIND_COEFF: if (it.index < NC) coeffs[it.index] = it.coeff;
      KIND_KNOT:  if (it.index < NK) knots[it.index] = it.knot;
      KIND_EVAL:  expected_q.push_back(spline_at(it.point));
      default: ;
    endcase
  endtask

  function automatic item_t mk(cbs_kind_e k, int idx, logic [31:0] c, logic [23:0] kn,
                               logic [23:0] p);
    item_t it;
    it.kind = k; it.index = idx[4:0]; it.coeff = c; it.knot = kn; it.point = p;
    return it;
  endfunction

  // Point near the knot span: mostly inside, sometimes right on a knot, sometimes anywhere
  function automatic logic [23:0] near_point();
    int k;
    k = $urandom_range(0, NK-1);
    case ($urandom_range(0, 3))
      0: return knots[k];
      1: return knots[k] + $urandom_range(0, 3) - 1;
      2: return $urandom;
      default: return knots[0] + $urandom_range(0, 6451200 + 12800);
    endcase
  endfunction

  // Driver: hold the beat until accepted, random gap between beats
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_item(pending_q.pop_front());
        send_wait <= $urandom_range(0, 3);
        s_axis_tvalid <= 1'b0;
      end else if (!s_axis_tvalid) begin
        if (send_wait > 0) begin
          send_wait <= send_wait - 1;
        end else if (pending_q.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= pending_q[0].kind;
          s_axis_tdata <= {3'b0, pending_q[0].point, pending_q[0].knot,
                           pending_q[0].coeff, pending_q[0].index};
        end
      end
    end
  end

  // Monitor: random back-pressure, compare each beat with the oldest result
  always @(posedge clk_i) begin
    result_t got, exp_r;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[31:0], m_axis_tdata[32], m_axis_tdata[33]};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected beat, actual %h", $time, got);
          errors++;
        end else begin
          exp_r = expected_q.pop_front();
          if (got.value !== exp_r.value) begin
            $display("%0t: value expected %h actual %h", $time, exp_r.value, got.value);
            errors++;
          end
          if (got.in_range !== exp_r.in_range) begin
            $display("%0t: in_range expected %b actual %b", $time, exp_r.in_range,
                     got.in_range);
            errors++;
          end
          if (got.sat !== exp_r.sat) begin
            $display("%0t: saturated expected %b actual %b", $time, exp_r.sat, got.sat);
            errors++;
          end
        end
        recv_wait <= $urandom_range(0, 3);
        m_axis_tready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait <= recv_wait - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    for (int j = 0; j < NK; j++) knots[j] = def_knot(7'(j));
    for (int i = 0; i < NC; i++) coeffs[i] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed: zero coefficients, extreme fields, edges, bad kind and index
    pending_q.push_back(mk(KIND_EVAL, 0, 0, 0, 24'd100));
    pending_q.push_back(mk(KIND_EVAL, 0, 0, 0, -24'sd12800));
    pending_q.push_back(mk(KIND_EVAL, 0, 0, 0, 24'sd6451200));
    pending_q.push_back(mk(KIND_EVAL, 0, 0, 0, 24'h7FFFFF));
    pending_q.push_back(mk(KIND_EVAL, 0, 0, 0, 24'h800000));
    for (int i = 0; i < NC; i++)
      pending_q.push_back(mk(KIND_COEFF, i, (i % 2) ? 32'h7FFFFFFF : 32'h80000000, 0, 0));
    pending_q.push_back(mk(KIND_COEFF, 31, 32'h12345678, 0, 0));
    pending_q.push_back(mk(KIND_KNOT, 31, 0, 24'h7FFFFF, 0));
    pending_q.push_back(mk(cbs_kind_e'(2'd3), 31, '1, '1, '1));
    pending_q.push_back(mk(KIND_EVAL, 0, 0, 0, 24'sd1000));
    pending_q.push_back(mk(KIND_EVAL, 0, 0, 0, 24'sd700000));
    // Random part: mostly evaluates with fresh coefficients, some knot edits
    for (int n = 0; n < 800; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: pending_q.push_back(mk(KIND_COEFF, $urandom_range(0, 15), $urandom, 0, 0));
        3: begin
          // repeat a neighbor to form zero gaps, or write a random value
          int k;
          k = $urandom_range(0, NK);
          if ($urandom_range(0, 1) && k > 0 && k < NK)
            pending_q.push_back(mk(KIND_KNOT, k, 0, knots[k-1], 0));
          else
            pending_q.push_back(mk(KIND_KNOT, k, 0, $urandom, 0));
        end
        4: pending_q.push_back(mk(cbs_kind_e'(2'd3), $urandom, $urandom, $urandom, $urandom));
        default: pending_q.push_back(mk(KIND_EVAL, $urandom, $urandom, $urandom, 0));
      endcase
      // knots only mirror state once applied; points use current table, fine
      if (pending_q[$].kind == KIND_EVAL) pending_q[$].point = near_point();
    end
    wait (pending_q.size() == 0 && !s_axis_tvalid);
    wait (expected_q.size() == 0);
    repeat (2000) @(posedge clk_i);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #200ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
